@@ rtl/bmf_pkg.sv @@
// Package for the batch median filter.
// Holds the sample type and the control and status structs shared by the
// datapath modules. No dependencies.
package bmf_pkg;

    localparam int SAMPLE_W = 12;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Commands from the top level to the selection engine
    typedef struct packed {
        logic start;   // last sample of the batch written this cycle
        logic take;    // result moved into the output register
    } bmf_cmd_t;

    // Status from the selection engine to the top level
    typedef struct packed {
        logic    idle;
        logic    done;
        sample_t median;
    } bmf_status_t;

endpackage

@@ rtl/bmf_sample_if.sv @@
// Valid/ready channel that carries one temperature sample a beat.
// Depends on bmf_pkg.
interface bmf_sample_if;
    import bmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ rtl/bmf_median_if.sv @@
// Valid/ready channel that carries one batch median a beat.
// Depends on bmf_pkg.
interface bmf_median_if;
    import bmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

@@ rtl/bmf_store.sv @@
// Sample memory of the batch median filter: one write port, one read port,
// registered read data. Depends on bmf_pkg.
module bmf_store #(
    parameter int WINDOW = 20
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(WINDOW)-1:0]    wr_addr,
    input  bmf_pkg::sample_t             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(WINDOW)-1:0]    rd_addr,
    output bmf_pkg::sample_t             rd_data
);
    import bmf_pkg::*;

    sample_t mem [WINDOW];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bmf_rank.sv @@
// Selection engine: finds the element of stable rank WINDOW/2 in the stored
// batch by counting, for each candidate, the entries that sort before it.
// Depends on bmf_pkg; drives the read port of bmf_store.
module bmf_rank #(
    parameter int WINDOW = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmf_pkg::bmf_cmd_t            cmd,
    output bmf_pkg::bmf_status_t         status,
    output logic                         rd_en,
    output logic [$clog2(WINDOW)-1:0]    rd_addr,
    input  bmf_pkg::sample_t             rd_data
);
    import bmf_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] MID  = AW'(WINDOW / 2);
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    typedef enum logic [1:0] {S_IDLE, S_CAND, S_SCAN, S_DONE} state_t;

    state_t         state_reg;
    logic [AW-1:0]  cand_idx_reg;
    logic [AW-1:0]  scan_idx_reg;
    logic [AW-1:0]  rank_reg;
    sample_t        cand_reg;
    sample_t        median_reg;

    logic           is_before;
    logic [AW-1:0]  rank_sum;
    logic           last_scan;
    logic           found;

    // An entry sorts before the candidate if smaller, or equal and earlier
    assign is_before = (rd_data < cand_reg) ||
                       ((rd_data == cand_reg) && (scan_idx_reg < cand_idx_reg));
    assign rank_sum  = rank_reg + AW'(is_before);
    assign last_scan = (scan_idx_reg == LAST);
    assign found     = last_scan && (rank_sum == MID);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = cmd.start;
                rd_addr = '0;
            end
            S_CAND:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_SCAN:
            begin
                rd_en   = !found;
                rd_addr = last_scan ? cand_idx_reg + 1'b1 : scan_idx_reg + 1'b1;
            end
            S_DONE:
            begin
                rd_en   = 1'b0;
            end
            default:
            begin
                rd_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cand_idx_reg <= '0;
            scan_idx_reg <= '0;
            rank_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        cand_idx_reg <= '0;
                        state_reg    <= S_CAND;
                    end
                end
                S_CAND:
                begin
                    scan_idx_reg <= '0;
                    rank_reg     <= '0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (found)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (last_scan)
                    begin
                        // advance to the next candidate
                        cand_idx_reg <= cand_idx_reg + 1'b1;
                        state_reg    <= S_CAND;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        rank_reg     <= rank_sum;
                    end
                end
                S_DONE:
                begin
                    if (cmd.take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CAND)
        begin
            cand_reg <= rd_data;
        end
        if (state_reg == S_SCAN && found)
        begin
            median_reg <= cand_reg;
        end
    end

    assign status.idle   = (state_reg == S_IDLE);
    assign status.done   = (state_reg == S_DONE);
    assign status.median = median_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == S_IDLE)
        else $error("batch start while selection is running");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !cmd.take |=> (state_reg == S_DONE) && $stable(median_reg))
        else $error("pending median lost before hand-over");

    a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cand_idx_reg <= LAST && scan_idx_reg <= LAST)
        else $error("candidate or scan index beyond the batch");

    a_take_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> state_reg == S_DONE)
        else $error("result taken with no median ready");

endmodule

@@ rtl/batch_median_filter.sv @@
// Batch median filter. Collects WINDOW signed 12-bit samples (1/16 degree C)
// into a one-port-read memory, one sample a beat with no stall while a batch
// fills. The beat that completes a batch starts a selection pass that returns
// the element at index WINDOW/2 of the ascending-sorted batch (the upper
// median for an even window), then a new batch begins. The pass examines
// candidates in order and, for each, reads all WINDOW entries through the
// single memory read port. No sample is accepted during the pass, nor while
// a finished median waits for a free output register; the output register
// lets the next batch fill while the previous median is still held.
// Depends on bmf_pkg, bmf_sample_if, bmf_median_if, bmf_store, bmf_rank.
module batch_median_filter #(
    parameter int WINDOW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    bmf_sample_if.sink    feed,
    bmf_median_if.source  result
);
    import bmf_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    logic [AW-1:0]  fill_reg;
    logic           out_valid_reg;
    sample_t        out_median_reg;

    bmf_cmd_t       cmd;
    bmf_status_t    status;
    logic           accept;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    sample_t        rd_data;

    assign feed.ready = status.idle;
    assign accept     = feed.valid && status.idle;
    assign cmd.start  = accept && (fill_reg == LAST);
    assign cmd.take   = status.done && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= (fill_reg == LAST) ? '0 : fill_reg + 1'b1;
            end
            if (cmd.take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            out_median_reg <= status.median;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.median = out_median_reg;

    bmf_store #(.WINDOW(WINDOW)) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (fill_reg),
        .wr_data (feed.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmf_rank #(.WINDOW(WINDOW)) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
